// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the barometric pressure compensation block.
// No dependencies.
package bpc_pkg;

  localparam int DIV_STEPS   = 32;
  localparam int DIV_SIDE_W  = 53;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_ADDR_W  = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_OSS  = 3'd0;
  localparam logic [2:0] REG_AC12 = 3'd1;
  localparam logic [2:0] REG_AC34 = 3'd2;
  localparam logic [2:0] REG_AC56 = 3'd3;
  localparam logic [2:0] REG_B12  = 3'd4;
  localparam logic [2:0] REG_MCMD = 3'd5;

  localparam logic [31:0] C_T_OFF    = 32'd4000;
  localparam logic [31:0] C_B4_OFF   = 32'd32768;
  localparam logic [31:0] C_B7_SCALE = 32'd50000;
  localparam logic [31:0] C_P1       = 32'd3038;
  localparam logic [31:0] C_P2       = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] C_P3       = 32'd3791;
  localparam logic [31:0] C_PMAX     = 32'd1048575;

  typedef struct packed {
    logic [1:0]  oss;
    logic [31:0] ac12;
    logic [31:0] ac34;
    logic [31:0] ac56;
    logic [31:0] b12;
    logic [31:0] mcmd;
  } bpc_cfg_t;

  typedef struct packed {
    logic [18:0] raw_press;
    logic [15:0] raw_temp;
  } bpc_item_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- sv/bpc_regs.sv -----
`timescale 1ns / 1ps
// APB-style register file holding oversampling and calibration coefficients.
// Depends on bpc_pkg.
module bpc_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output bpc_pkg::bpc_cfg_t         cfg
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_r;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_OSS:  cfg_r.oss  <= pwdata[1:0];
        REG_AC12: cfg_r.ac12 <= pwdata;
        REG_AC34: cfg_r.ac34 <= pwdata;
        REG_AC56: cfg_r.ac56 <= pwdata;
        REG_B12:  cfg_r.b12  <= pwdata;
        REG_MCMD: cfg_r.mcmd <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_OSS:  prdata = {30'd0, cfg_r.oss};
      REG_AC12: prdata = cfg_r.ac12;
      REG_AC34: prdata = cfg_r.ac34;
      REG_AC56: prdata = cfg_r.ac56;
      REG_B12:  prdata = cfg_r.b12;
      REG_MCMD: prdata = cfg_r.mcmd;
      default:  prdata = '0;
    endcase
  end

endmodule

// ----- sv/bpc_front.sv -----
`timescale 1ns / 1ps
// Input side: accepts reading pairs and holds them in a short queue for the datapath.
// Depends on bpc_pkg.
module bpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpc_pkg::bpc_item_t  in_item,
  output logic                q_valid,
  output bpc_pkg::bpc_item_t  q_item,
  input  logic                q_pop
);
  import bpc_pkg::*;

  bpc_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_r, rptr_r;
  logic [QPTR_W:0]    cnt_r;
  logic               push, pop;

  assign in_ready = (cnt_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= in_item;
  end

endmodule

// ----- sv/bpc_div.sv -----
`timescale 1ns / 1ps
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage,
// with a sideband word that travels alongside. Depends on bpc_pkg.
module bpc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [31:0]            in_dvd,
  input  logic [31:0]            in_dsr,
  input  logic [bpc_pkg::DIV_SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [31:0]            out_quo,
  output logic [bpc_pkg::DIV_SIDE_W-1:0] out_side
);
  import bpc_pkg::*;

  logic [31:0]           rem_r  [DIV_STEPS];
  logic [31:0]           quo_r  [DIV_STEPS];
  logic [31:0]           dsr_r  [DIV_STEPS];
  logic [DIV_SIDE_W-1:0] side_r [DIV_STEPS];
  logic [DIV_STEPS-1:0]  v_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0]           rem_in, quo_in, dsr_in;
    logic [DIV_SIDE_W-1:0] side_in;
    logic                  v_in;
    logic [32:0]           trial, diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = in_dvd;
      assign dsr_in  = in_dsr;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign dsr_in  = dsr_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, quo_in[31]};
    assign diff  = trial - {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[32]) begin
          rem_r[k] <= diff[31:0];
          quo_r[k] <= {quo_in[30:0], 1'b1};
        end else begin
          rem_r[k] <= trial[31:0];
          quo_r[k] <= {quo_in[30:0], 1'b0};
        end
        dsr_r[k]  <= dsr_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_quo   = quo_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

// ----- sv/bpc_back.sv -----
`timescale 1ns / 1ps
// Compensation datapath: temperature, b3/b4/b7 terms, two pipelined divisions,
// pressure correction and saturation. Depends on bpc_pkg and bpc_div.
module bpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bpc_pkg::bpc_cfg_t   cfg,
  input  logic                q_valid,
  input  bpc_pkg::bpc_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_temp,
  output logic [19:0]         out_press,
  output logic                out_fault
);
  import bpc_pkg::*;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic        adv;

  assign ac1 = sext16(cfg.ac12[31:16]);
  assign ac2 = sext16(cfg.ac12[15:0]);
  assign ac3 = sext16(cfg.ac34[31:16]);
  assign ac4 = {16'd0, cfg.ac34[15:0]};
  assign ac5 = {16'd0, cfg.ac56[31:16]};
  assign ac6 = {16'd0, cfg.ac56[15:0]};
  assign b1  = sext16(cfg.b12[31:16]);
  assign b2  = sext16(cfg.b12[15:0]);
  assign mc  = sext16(cfg.mcmd[31:16]);
  assign md  = sext16(cfg.mcmd[15:0]);

  // whole pipeline moves when the output register is free or drained
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv;

  // stage valids
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic s9_v_r, s10_v_r, s11_v_r, s12_v_r, s13_v_r, s14_v_r, s15_v_r, out_v_r;
  logic d1_v, d2_v;

  // temperature front
  logic [31:0] s1_d_r;  logic [18:0] s1_up_r;
  logic [31:0] s2_m_r;  logic [18:0] s2_up_r;
  logic [31:0] s3_x1_r, s3_den_r, s3_num_r; logic [18:0] s3_up_r;
  logic [31:0] s4_ma_r, s4_mb_r, s4_x1_r; logic s4_neg_r, s4_flt_r; logic [18:0] s4_up_r;
  logic [31:0] d1_q;    logic [DIV_SIDE_W-1:0] d1_side;
  logic [31:0] d1_x1;   logic [18:0] d1_up; logic d1_neg, d1_flt;
  logic [31:0] s5_x2;
  logic [31:0] s5_b5_r, s5_b6_r; logic [18:0] s5_up_r; logic s5_flt_r;
  // pressure terms
  logic [31:0] s6_sq_r, s6_t2_r, s6_t3_r, s6_b5_r; logic [18:0] s6_up_r; logic s6_flt_r;
  logic [31:0] s7_y1_r, s7_y2_r, s7_t2_r, s7_t3_r, s7_b5_r; logic [18:0] s7_up_r; logic s7_flt_r;
  logic [31:0] s8_x3, s8_sum, s8_shl, s8_b3_nxt, s8_x3b_nxt;
  logic [31:0] s8_b3_r, s8_x3b_r, s8_b5_r; logic [18:0] s8_up_r; logic s8_flt_r;
  logic [31:0] s9_prod;
  logic [31:0] s9_b4_r, s9_d7_r, s9_b5_r; logic s9_flt_r;
  logic [31:0] s10_b7_r, s10_b4_r, s10_b5_r; logic s10_flt_r;
  logic [31:0] s11_dvd_r, s11_b4_r, s11_b5_r; logic s11_big_r, s11_flt_r;
  logic [31:0] d2_q;    logic [DIV_SIDE_W-1:0] d2_side;
  logic [31:0] d2_b5;   logic d2_big, d2_flt;
  logic [31:0] s12_p_nxt;
  logic [31:0] s12_p_r, s12_h_r, s12_b5_r; logic s12_flt_r;
  logic [31:0] s13_hh_r, s13_p_r, s13_b5_r; logic s13_flt_r;
  logic [31:0] s14_z1_r, s14_z2_r, s14_p_r, s14_b5_r; logic s14_flt_r;
  logic [31:0] s15_zs;
  logic [31:0] s15_p_r, s15_b5_r; logic s15_flt_r;
  logic [31:0] out_t32, out_p32;
  logic [15:0] temp_nxt, temp_r;
  logic [19:0] press_nxt, press_r;
  logic        fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r} <= '0;
      {s9_v_r, s10_v_r, s11_v_r, s12_v_r, s13_v_r, s14_v_r, s15_v_r, out_v_r} <= '0;
    end else if (adv) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= d1_v;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
      s12_v_r <= d2_v;
      s13_v_r <= s12_v_r;
      s14_v_r <= s13_v_r;
      s15_v_r <= s14_v_r;
      out_v_r <= s15_v_r;
    end
  end

  // first division: x2 = mc*2048 / (x1 + md), signed via magnitudes
  bpc_div u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s4_v_r),
    .in_dvd   (s4_ma_r),
    .in_dsr   (s4_mb_r),
    .in_side  ({s4_flt_r, s4_neg_r, s4_up_r, s4_x1_r}),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_side (d1_side)
  );
  assign {d1_flt, d1_neg, d1_up, d1_x1} = d1_side;
  assign s5_x2 = d1_neg ? (32'd0 - d1_q) : d1_q;

  assign s8_x3      = s7_y1_r + s7_t2_r;
  assign s8_sum     = (ac1 << 2) + s8_x3;
  assign s8_shl     = (s8_sum << cfg.oss) + 32'd2;
  assign s8_b3_nxt  = 32'($signed(s8_shl) >>> 2);
  assign s8_x3b_nxt = 32'($signed(s7_t3_r + s7_y2_r + 32'd2) >>> 2);
  assign s9_prod    = ac4 * (s8_x3b_r + C_B4_OFF);

  // second division: p from b7 / b4, halved dividend path when b7 top bit set
  bpc_div u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s11_v_r),
    .in_dvd   (s11_dvd_r),
    .in_dsr   (s11_b4_r),
    .in_side  ({19'd0, s11_flt_r, s11_big_r, s11_b5_r}),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_side (d2_side)
  );
  assign d2_b5     = d2_side[31:0];
  assign d2_big    = d2_side[32];
  assign d2_flt    = d2_side[33];
  assign s12_p_nxt = d2_big ? (d2_q << 1) : d2_q;

  assign s15_zs = 32'($signed(s14_z1_r + s14_z2_r + C_P3) >>> 4);

  assign out_t32 = 32'($signed(s15_b5_r + 32'd8) >>> 4);
  assign out_p32 = s15_p_r;

  always_comb begin
    if ($signed(out_t32) > 32'sd32767) begin
      temp_nxt = 16'h7FFF;
    end else if ($signed(out_t32) < -32'sd32768) begin
      temp_nxt = 16'h8000;
    end else begin
      temp_nxt = out_t32[15:0];
    end
    if (out_p32[31]) begin
      press_nxt = '0;
    end else if (out_p32 > C_PMAX) begin
      press_nxt = C_PMAX[19:0];
    end else begin
      press_nxt = out_p32[19:0];
    end
    if (s15_flt_r) begin
      temp_nxt  = '0;
      press_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d_r    <= {16'd0, q_item.raw_temp} - ac6;
      s1_up_r   <= q_item.raw_press;

      s2_m_r    <= s1_d_r * ac5;
      s2_up_r   <= s1_up_r;

      s3_x1_r   <= 32'($signed(s2_m_r) >>> 15);
      s3_den_r  <= 32'($signed(s2_m_r) >>> 15) + md;
      s3_num_r  <= mc << 11;
      s3_up_r   <= s2_up_r;

      s4_flt_r  <= (s3_den_r == '0);
      s4_ma_r   <= s3_num_r[31] ? (32'd0 - s3_num_r) : s3_num_r;
      s4_mb_r   <= s3_den_r[31] ? (32'd0 - s3_den_r) : s3_den_r;
      s4_neg_r  <= s3_num_r[31] ^ s3_den_r[31];
      s4_x1_r   <= s3_x1_r;
      s4_up_r   <= s3_up_r;

      s5_b5_r   <= d1_x1 + s5_x2;
      s5_b6_r   <= d1_x1 + s5_x2 - C_T_OFF;
      s5_up_r   <= d1_up;
      s5_flt_r  <= d1_flt;

      s6_sq_r   <= 32'($signed(32'(s5_b6_r * s5_b6_r)) >>> 12);
      s6_t2_r   <= 32'($signed(32'(ac2 * s5_b6_r)) >>> 11);
      s6_t3_r   <= 32'($signed(32'(ac3 * s5_b6_r)) >>> 13);
      s6_b5_r   <= s5_b5_r;
      s6_up_r   <= s5_up_r;
      s6_flt_r  <= s5_flt_r;

      s7_y1_r   <= 32'($signed(32'(b2 * s6_sq_r)) >>> 11);
      s7_y2_r   <= 32'($signed(32'(b1 * s6_sq_r)) >>> 16);
      s7_t2_r   <= s6_t2_r;
      s7_t3_r   <= s6_t3_r;
      s7_b5_r   <= s6_b5_r;
      s7_up_r   <= s6_up_r;
      s7_flt_r  <= s6_flt_r;

      s8_b3_r   <= s8_b3_nxt;
      s8_x3b_r  <= s8_x3b_nxt;
      s8_b5_r   <= s7_b5_r;
      s8_up_r   <= s7_up_r;
      s8_flt_r  <= s7_flt_r;

      s9_b4_r   <= s9_prod >> 15;
      s9_d7_r   <= {13'd0, s8_up_r} - s8_b3_r;
      s9_b5_r   <= s8_b5_r;
      s9_flt_r  <= s8_flt_r;

      s10_b7_r  <= s9_d7_r * (C_B7_SCALE >> cfg.oss);
      s10_b4_r  <= s9_b4_r;
      s10_b5_r  <= s9_b5_r;
      s10_flt_r <= s9_flt_r || (s9_b4_r == '0);

      s11_big_r <= s10_b7_r[31];
      s11_dvd_r <= s10_b7_r[31] ? s10_b7_r : (s10_b7_r << 1);
      s11_b4_r  <= s10_b4_r;
      s11_b5_r  <= s10_b5_r;
      s11_flt_r <= s10_flt_r;

      s12_p_r   <= s12_p_nxt;
      s12_h_r   <= 32'($signed(s12_p_nxt) >>> 8);
      s12_b5_r  <= d2_b5;
      s12_flt_r <= d2_flt;

      s13_hh_r  <= s12_h_r * s12_h_r;
      s13_p_r   <= s12_p_r;
      s13_b5_r  <= s12_b5_r;
      s13_flt_r <= s12_flt_r;

      s14_z1_r  <= 32'($signed(32'(s13_hh_r * C_P1)) >>> 16);
      s14_z2_r  <= 32'($signed(32'(C_P2 * s13_p_r)) >>> 16);
      s14_p_r   <= s13_p_r;
      s14_b5_r  <= s13_b5_r;
      s14_flt_r <= s13_flt_r;

      s15_p_r   <= s14_p_r + s15_zs;
      s15_b5_r  <= s14_b5_r;
      s15_flt_r <= s14_flt_r;

      temp_r    <= temp_nxt;
      press_r   <= press_nxt;
      fault_r   <= s15_flt_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_temp  = temp_r;
  assign out_press = press_r;
  assign out_fault = fault_r;

endmodule

// ----- sv/barometric_pressure_compensation.sv -----
`timescale 1ns / 1ps
// Path: an accepted reading pair passes through two 32-stage dividers plus 16 arithmetic
// stages on its way to the output, and waits while out_tready is held low.
// Throughput: one word per cycle while out_tready is not held low, set by the fully pipelined dividers.
// A four-entry input queue absorbs output stalls; the datapath stalls as one.
// Reset (rst_n low, synchronous) empties queue and pipeline and clears the config registers.
module barometric_pressure_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // raw_temp[15:0], raw_press[34:16], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // temp_tenths[15:0], press_pa[35:16], zero pad
  output logic        out_tuser,  // div_fault
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpc_pkg::*;

  bpc_cfg_t    cfg;
  bpc_item_t   in_item, q_item;
  logic        q_valid, q_pop;
  logic [15:0] temp;
  logic [19:0] press;

  assign in_item.raw_temp  = in_tdata[15:0];
  assign in_item.raw_press = in_tdata[34:16];

  bpc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  bpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  bpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_temp (temp),
    .out_press(press),
    .out_fault(out_tuser)
  );

  assign out_tdata = {4'd0, press, temp};

endmodule

// ----- sv/bpc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for barometric_pressure_compensation, bound to the top level.
// Depends on the top level's ports only.
module bpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[35:0] == 36'd0)
    else $error("fault word carries nonzero results");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'd0)
    else $error("output pad bits set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_pready: assert property (@(posedge clk)
    cfg_pready)
    else $error("config port not ready");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for barometric_pressure_compensation: APB register setup, random and directed
// reading pairs, and a scoreboard that predicts temperature, pressure and divide fault.
// Depends on bpc_pkg and the block's RTL.
import bpc_pkg::*;

typedef struct packed {
  logic [15:0] temp;
  logic [19:0] press;
  logic        fault;
} comp_result_t;

class comp_scoreboard;
  logic [1:0]  oss;
  logic [31:0] ac12, ac34, ac56, b12, mcmd;
  comp_result_t pending[$];
  int errors;
  int checked;

  function new();
    oss = 0; ac12 = 0; ac34 = 0; ac56 = 0; b12 = 0; mcmd = 0;
    errors = 0; checked = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_OSS:  oss  = v[1:0];
      REG_AC12: ac12 = v;
      REG_AC34: ac34 = v;
      REG_AC56: ac56 = v;
      REG_B12:  b12  = v;
      REG_MCMD: mcmd = v;
      default: ;
    endcase
  endfunction

  static function logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  static function logic [31:0] sra(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  static function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function comp_result_t compensate(logic [15:0] ut16, logic [18:0] up19);
    logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, h, tw;
    comp_result_t r;
    ut = {16'd0, ut16}; up = {13'd0, up19};
    ac1 = ext16(ac12[31:16]); ac2 = ext16(ac12[15:0]);
    ac3 = ext16(ac34[31:16]); ac4 = {16'd0, ac34[15:0]};
    ac5 = {16'd0, ac56[31:16]}; ac6 = {16'd0, ac56[15:0]};
    b1 = ext16(b12[31:16]); b2 = ext16(b12[15:0]);
    mc = ext16(mcmd[31:16]); md = ext16(mcmd[15:0]);
    r = '{temp: 16'd0, press: 20'd0, fault: 1'b1};
    x1 = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = div_trunc(mc * 32'd2048, den);
    b5 = x1 + x2;
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    h = sra(p, 8);
    x1 = sra((h * h) * 32'd3038, 16);
    x2 = sra(32'hFFFF_E343 * p, 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    tw = sra(b5 + 32'd8, 4);
    if ($signed(tw) > 32767) r.temp = 16'h7FFF;
    else if ($signed(tw) < -32768) r.temp = 16'h8000;
    else r.temp = tw[15:0];
    if (p[31]) r.press = 0;
    else if (p > 32'd1048575) r.press = 20'hFFFFF;
    else r.press = p[19:0];
    r.fault = 1'b0;
    return r;
  endfunction

  function void note_reading(logic [39:0] d);
    pending.push_back(compensate(d[15:0], d[34:16]));
  endfunction

  function void check_result(logic [39:0] d, logic f);
    comp_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result temp=%h press=%h fault=%b", $time, d[15:0],
               d[35:16], f);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (d[15:0] !== e.temp) begin
      $display("%0t: temp_tenths expected %h got %h", $time, e.temp, d[15:0]);
      errors++;
    end
    if (d[35:16] !== e.press) begin
      $display("%0t: press_pa expected %h got %h", $time, e.press, d[35:16]);
      errors++;
    end
    if (f !== e.fault) begin
      $display("%0t: div_fault expected %b got %b", $time, e.fault, f);
      errors++;
    end
    if (d[39:36] !== 4'd0) begin
      $display("%0t: pad expected 0 got %h", $time, d[39:36]);
      errors++;
    end
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  comp_scoreboard sb;
  int  cycles;
  bit  idle_on;     // random gaps allowed
  int  hold_off;    // receiver hold-off cycles requested
  int  sent;

  localparam int LIMIT = 2_000_000;

  barometric_pressure_compensation dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);

  // receiver: random stall bursts, or a long hold-off on request
  initial begin
    int n;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready = 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_tready = 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready = 1;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  task automatic send_reading(logic [15:0] t, logic [18:0] p);
    int n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 5);
      in_tvalid = 0;
      repeat (n) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {5'd0, p, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_reading(in_tdata);
    sent++;
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // typical calibration set with a little random spread
  task automatic program_coefs(bit spread, logic [1:0] oss);
    apb_write(REG_OSS, {30'd0, oss});
    apb_write(REG_AC12, {16'd408 + (spread ? 16'($urandom_range(0, 200)) : 16'd0),
                         16'hFFB8});
    apb_write(REG_AC34, {16'hC610, 16'd32741 + (spread ? 16'($urandom_range(0, 500)) : 16'd0)});
    apb_write(REG_AC56, {16'd32757, 16'd23153 + (spread ? 16'($urandom_range(0, 900)) : 16'd0)});
    apb_write(REG_B12,  {16'd6190, 16'd4});
    apb_write(REG_MCMD, {16'h8000 - 16'd0 + 16'd0 - 16'd8711 + 16'h8000, 16'd2868});
  endtask

  task automatic random_phase(int cnt, bit plausible);
    for (int i = 0; i < cnt; i++) begin
      if (plausible && $urandom_range(0, 9) != 0)
        send_reading(16'($urandom_range(20000, 35000)), 19'($urandom_range(10000, 120000)));
      else
        send_reading(16'($urandom), 19'($urandom));
    end
  endtask

  initial begin
    logic [2:0] r;
    sb = new();
    cycles = 0; idle_on = 1; hold_off = 0; sent = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // reset values: every divisor is zero, so each item faults
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    drain();

    // directed: datasheet-like set, extreme readings and every oversampling
    program_coefs(0, 2'd0);
    send_reading(16'd27898, 19'd23843);
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'hFFFF, 19'd0);
    send_reading(16'd0, 19'h7FFFF);
    for (int o = 1; o < 4; o++) begin
      drain();
      apb_write(REG_OSS, o);
      send_reading(16'd27898, 19'd23843 << o);
      send_reading(16'd30000, 19'h7FFFF);
    end
    drain();
    // zero temperature divisor: ac5 = 0, md = 0
    apb_write(REG_AC56, 32'h0000_5A71);
    apb_write(REG_MCMD, 32'hDDF9_0000);
    send_reading(16'd1234, 19'd5678);
    drain();
    // zero b4: ac4 = 0
    program_coefs(0, 2'd3);
    apb_write(REG_AC34, 32'hC610_0000);
    send_reading(16'd27898, 19'd23843);
    drain();
    // extreme coefficients push through wrap and saturation
    apb_write(REG_OSS, 32'hFFFF_FFFF);
    apb_write(REG_AC12, 32'hFFFF_FFFF);
    apb_write(REG_AC34, 32'h8000_FFFF);
    apb_write(REG_AC56, 32'hFFFF_0000);
    apb_write(REG_B12, 32'h7FFF_8000);
    apb_write(REG_MCMD, 32'h7FFF_7FFF);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'h0000, 19'h00000);
    send_reading(16'h8000, 19'h40000);
    drain();
    apb_write(REG_AC12, 32'h0000_0000);
    apb_write(REG_AC34, 32'h7FFF_0001);
    apb_write(REG_MCMD, 32'h8000_8000);
    send_reading(16'h5555, 19'h2AAAA);
    send_reading(16'hAAAA, 19'h55555);
    drain();

    // random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      program_coefs(1, 2'($urandom_range(0, 3)));
      if (ph == 2) hold_off = 300;   // fill the pipe and stall input
      random_phase(130, 1);
      drain();
    end
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 6; k++) begin
        r = 3'(k);
        apb_write(r, $urandom);
      end
      random_phase(80, 0);
      drain();
    end
    // back to back, no idling
    idle_on = 0;
    program_coefs(1, 2'd1);
    random_phase(200, 1);
    drain();

    $display("Sent %0d reading pairs, checked %0d results over reset, directed",
             sent, sb.checked);
    $display("extreme and random coefficient settings with all oversampling modes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- barometric_pressure_compensation.f -----
sv/bpc_pkg.sv
sv/bpc_regs.sv
sv/bpc_front.sv
sv/bpc_div.sv
sv/bpc_back.sv
sv/barometric_pressure_compensation.sv
sv/bpc_checker.sv
tb/sv/tb.sv
